### design/ofdm_pilot_insert_remove_core_defines.svh
// Assertion macros for the pilot insert/remove RTL.
// Depends on nothing; modules that assert include this file by name.
`ifndef OFDM_PILOT_INSERT_REMOVE_CORE_DEFINES_SVH
`define OFDM_PILOT_INSERT_REMOVE_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define OPIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define OPIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/ofdm_pir_pkg.sv
// Shared constants and types for the OFDM pilot insert/remove core.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ofdm_pir_pkg;

    localparam int MAX_PILOTS   = 16;
    localparam int MAX_SYMBOL   = 1024;
    localparam int SAMPLE_WIDTH = 16;

    // Field widths
    localparam int SLOT_W   = $clog2(MAX_PILOTS);
    localparam int PTR_W    = $clog2(MAX_PILOTS + 1);
    localparam int PPOS_W   = 10;
    localparam int POS_W    = $clog2(2 * MAX_SYMBOL);
    localparam int CNT_W    = 5;
    localparam int ENTRY_W  = PPOS_W + 2 * SAMPLE_WIDTH;

    // Input tdata layout, lowest bit first
    localparam int S_SLOT_LO = 0;
    localparam int S_PPOS_LO = S_SLOT_LO + SLOT_W;
    localparam int S_RE_LO   = S_PPOS_LO + PPOS_W;
    localparam int S_IM_LO   = S_RE_LO + SAMPLE_WIDTH;
    localparam int S_USED_W  = S_IM_LO + SAMPLE_WIDTH;
    localparam int S_DATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

    // Item kinds carried in s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // One pilot table entry as stored in memory
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] imag;
        logic signed [SAMPLE_WIDTH-1:0] real_part;
        logic [PPOS_W-1:0]              position;
    } pilot_entry_t;

endpackage

`default_nettype wire

### design/ofdm_pir_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ofdm_pir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### design/ofdm_pilot_insert_remove_core.sv
// Top level of the OFDM pilot insert/remove core: sequencer, counters, output register.
// Depends on ofdm_pir_pkg, ofdm_pir_ram and ofdm_pilot_insert_remove_core_defines.svh.
//
//  Channel  Dir  Payload
//  s_       in   tdata: entry_slot, pilot_position, in_real, in_imag; tuser: op; tlast: last
//  m_       out  tdata: out_real, out_imag; tuser: is_pilot, run_end; tlast: symbol_end
//  cfg_     in   write: index 0 mode, index 1 pilot_count
//
// A data sample is taken in ST_IDLE; in insert mode ST_MATCH emits the pilots due ahead of it
// and then the sample, and ST_TRAIL the pilots left at symbol end. Results go out one per cycle
// while the output is free. The table is read every cycle at the next pointer, into a register.
// Reset (aresetn, synchronous) clears counters, pointer, registers and output valid.
// A stalled output holds the sequencer save a remove-mode drop; new input is taken only in idle.
`timescale 1ns / 1ps
`default_nettype none
`include "ofdm_pilot_insert_remove_core_defines.svh"

module ofdm_pilot_insert_remove_core (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [ofdm_pir_pkg::CNT_W-1:0]   cfg_wr_data,
    // Input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // tdata: entry_slot[3:0], pilot_position[13:4], in_real[29:14], in_imag[45:30], zero pad
    input  wire logic [ofdm_pir_pkg::S_DATA_W-1:0] s_tdata,
    // tuser: op
    input  wire logic                             s_tuser,
    input  wire logic                             s_tlast,
    // Result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // tdata: out_real[15:0], out_imag[31:16]
    output logic [ofdm_pir_pkg::M_DATA_W-1:0]     m_tdata,
    // tuser: is_pilot[0], run_end[1]
    output logic [1:0]                            m_tuser,
    output logic                                  m_tlast
);

    import ofdm_pir_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_TRAIL
    } state_t;

    state_t                  state_reg, state_next;
    logic                    mode_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [PTR_W-1:0]        ptr_reg, ptr_next;
    logic [SAMPLE_WIDTH-1:0] smp_re_reg, smp_im_reg;
    logic                    smp_last_reg;

    logic                    out_valid_reg;
    logic [SAMPLE_WIDTH-1:0] out_re_reg, out_im_reg;
    logic                    out_pilot_reg, out_run_end_reg, out_sym_end_reg;

    logic                    emit;
    logic [SAMPLE_WIDTH-1:0] emit_re, emit_im;
    logic                    emit_pilot, emit_run_end, emit_sym_end;
    logic                    out_free;
    logic                    in_xfer;
    logic [PTR_W-1:0]        eff_cnt;
    logic                    ptr_live;
    logic                    pos_hit;
    logic [PTR_W-1:0]        ptr_inc;
    pilot_entry_t            wr_entry, rd_entry;
    logic [ENTRY_W-1:0]      rd_word;
    logic                    tbl_we;

    // Handshake and derived terms
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign eff_cnt  = (count_reg > CNT_W'(MAX_PILOTS)) ? PTR_W'(MAX_PILOTS)
                                                       : PTR_W'(count_reg);
    assign ptr_live = ptr_reg < eff_cnt;
    assign ptr_inc  = ptr_reg + PTR_W'(1);
    assign rd_entry = pilot_entry_t'(rd_word);
    assign pos_hit  = ptr_live && (POS_W'(rd_entry.position) == pos_reg);

    // Pilot table load
    assign tbl_we = in_xfer && (s_tuser == OP_LOAD)
                    && (PTR_W'(s_tdata[S_PPOS_LO-1:S_SLOT_LO]) < PTR_W'(MAX_PILOTS));
    always_comb begin
        wr_entry           = '0;
        wr_entry.position  = s_tdata[S_RE_LO-1:S_PPOS_LO];
        wr_entry.real_part = s_tdata[S_IM_LO-1:S_RE_LO];
        wr_entry.imag      = s_tdata[S_USED_W-1:S_IM_LO];
    end

    ofdm_pir_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PILOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (s_tdata[S_PPOS_LO-1:S_SLOT_LO]),
        .wr_data (wr_entry),
        .rd_addr (ptr_next[SLOT_W-1:0]),
        .rd_data (rd_word)
    );

    // Sequencer: one result per cycle while the output is free, the table is read at the next pointer
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        ptr_next     = ptr_reg;
        emit         = 1'b0;
        emit_re      = smp_re_reg;
        emit_im      = smp_im_reg;
        emit_pilot   = 1'b0;
        emit_run_end = 1'b0;
        emit_sym_end = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_tuser == OP_SAMPLE)) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (mode_reg == MODE_INSERT) begin
                    if (pos_hit) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            emit_re    = rd_entry.real_part;
                            emit_im    = rd_entry.imag;
                            emit_pilot = 1'b1;
                            ptr_next   = ptr_inc;
                            pos_next   = pos_reg + POS_W'(1);
                        end
                    end else if (out_free) begin
                        emit         = 1'b1;
                        emit_run_end = !(smp_last_reg && ptr_live);
                        emit_sym_end = smp_last_reg && !ptr_live;
                        pos_next     = pos_reg + POS_W'(1);
                        if (smp_last_reg && ptr_live) begin
                            state_next = ST_TRAIL;
                        end else begin
                            state_next = ST_IDLE;
                            if (smp_last_reg) begin
                                pos_next = '0;
                                ptr_next = '0;
                            end
                        end
                    end
                end else begin
                    // Remove mode: drop a sample that sits on a pilot position
                    if (pos_hit || out_free) begin
                        state_next = ST_IDLE;
                        pos_next   = pos_reg + POS_W'(1);
                        if (pos_hit) begin
                            ptr_next = ptr_inc;
                        end else begin
                            emit         = 1'b1;
                            emit_run_end = 1'b1;
                            emit_sym_end = smp_last_reg;
                        end
                        if (smp_last_reg) begin
                            pos_next = '0;
                            ptr_next = '0;
                        end
                    end
                end
            end
            ST_TRAIL: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_re      = rd_entry.real_part;
                    emit_im      = rd_entry.imag;
                    emit_pilot   = 1'b1;
                    emit_run_end = !(ptr_inc < eff_cnt);
                    emit_sym_end = !(ptr_inc < eff_cnt);
                    ptr_next     = ptr_inc;
                    if (!(ptr_inc < eff_cnt)) begin
                        state_next = ST_IDLE;
                        pos_next   = '0;
                        ptr_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters, configuration and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            mode_reg      <= MODE_INSERT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ptr_reg   <= ptr_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_MODE:  mode_reg  <= cfg_wr_data[0];
                    REG_COUNT: count_reg <= cfg_wr_data;
                    default:   ;
                endcase
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            smp_re_reg   <= s_tdata[S_IM_LO-1:S_RE_LO];
            smp_im_reg   <= s_tdata[S_USED_W-1:S_IM_LO];
            smp_last_reg <= s_tlast;
        end
        if (emit) begin
            out_re_reg      <= emit_re;
            out_im_reg      <= emit_im;
            out_pilot_reg   <= emit_pilot;
            out_run_end_reg <= emit_run_end;
            out_sym_end_reg <= emit_sym_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_im_reg, out_re_reg});
    assign m_tuser  = {out_run_end_reg, out_pilot_reg};
    assign m_tlast  = out_sym_end_reg;

    // Checks
    `OPIR_ASSERT(a_emit_into_free, emit |-> out_free,
                 "result loaded into a full output register")
    `OPIR_ASSERT(a_symend_runend, (m_tvalid && m_tlast) |-> m_tuser[1],
                 "symbol end without run end")
    `OPIR_ASSERT(a_symend_clears,
                 (emit && emit_sym_end) |=> (ptr_reg == '0 && pos_reg == '0),
                 "counters not cleared at symbol end")
    `OPIR_ASSERT(a_ptr_step,
                 (state_reg != ST_IDLE) |=> (ptr_reg == $past(ptr_reg)
                     || ptr_reg == $past(ptr_inc) || ptr_reg == '0),
                 "pilot pointer jumped")
    `OPIR_ASSERT(a_idle_ready, s_tready == (state_reg == ST_IDLE),
                 "input ready outside idle")
    `OPIR_ASSERT_ALWAYS(a_reset_clears_valid, !aresetn |=> !m_tvalid,
                        "result valid right after reset")

endmodule

`default_nettype wire

### verif/ofdm_pilot_insert_remove_core_test.sv
// Self-checking testbench for the OFDM pilot insert/remove core.
// Depends on ofdm_pir_pkg and ofdm_pilot_insert_remove_core; predicts every result
// from its own copy of the pilot table, counters and registers.
`timescale 1ns / 1ps

module ofdm_pilot_insert_remove_core_test;
    import ofdm_pir_pkg::*;

    localparam int SETTLE_CYCLES  = 10;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 365;
    localparam int MAX_WAIT       = 17;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

    // One entry of the stimulus plan: an input transfer, a register write or a pause.
    typedef struct {
        step_kind_t              kind;
        logic                    op;
        logic [SLOT_W-1:0]       slot;
        logic [PPOS_W-1:0]       ppos;
        logic [SAMPLE_WIDTH-1:0] re;
        logic [SAMPLE_WIDTH-1:0] im;
        logic                    last;
        logic                    reg_idx;
        logic [CNT_W-1:0]        reg_val;
    } stim_step_t;

    // One emitted subcarrier as seen on the result stream.
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] re;
        logic [SAMPLE_WIDTH-1:0] im;
        logic                    pilot;
        logic                    run_end;
        logic                    sym_end;
    } carrier_out_t;

    // Clock, reset and block inputs, all known from time zero
    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic                    cfg_index   = 1'b0;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata     = '0;
    logic                    s_tuser     = 1'b0;
    logic                    s_tlast     = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic [1:0]              m_tuser;
    logic                    m_tlast;

    // Stimulus plan and expected carriers
    stim_step_t   pending_steps[$];
    carrier_out_t expected_carriers[$];
    int           items_queued = 0;
    int           error_count  = 0;
    int           settle_cycles = 0;

    // Predictor copy of the block state and registers
    logic [PPOS_W-1:0]       tbl_pos [MAX_PILOTS];
    logic [SAMPLE_WIDTH-1:0] tbl_re  [MAX_PILOTS];
    logic [SAMPLE_WIDTH-1:0] tbl_im  [MAX_PILOTS];
    logic [POS_W-1:0]        out_pos   = '0;
    int unsigned             tbl_ptr   = 0;
    logic                    cfg_mode  = MODE_INSERT;
    logic [CNT_W-1:0]        cfg_count = '0;

    // Driver and receiver private state
    stim_step_t          tx_cur;
    stim_step_t          head;
    bit                  tx_busy  = 0;
    bit                  tx_burst = 0;
    int                  tx_gap   = 0;
    logic                cfg_en_nxt;
    logic [S_DATA_W-1:0] tx_word;
    int                  rx_wait  = 0;
    bit                  rx_burst = 0;
    int                  idle_cycles = 0;
    carrier_out_t        seen;
    carrier_out_t        want;

    ofdm_pilot_insert_remove_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial forever #1 aclk = ~aclk;

    // ---------------------------------------------------------------- plan building

    function automatic void add_load(input logic [SLOT_W-1:0] slot,
                                     input logic [PPOS_W-1:0] ppos,
                                     input logic [SAMPLE_WIDTH-1:0] re,
                                     input logic [SAMPLE_WIDTH-1:0] im);
        stim_step_t st;
        st.kind = STEP_ITEM;
        st.op   = OP_LOAD;
        st.slot = slot;
        st.ppos = ppos;
        st.re   = re;
        st.im   = im;
        // The last flag means nothing on a table load, so it carries noise.
        st.last = 1'($urandom_range(0, 1));
        st.reg_idx = REG_MODE;
        st.reg_val = '0;
        pending_steps.push_back(st);
        items_queued++;
    endfunction

    function automatic void add_sample(input logic [SAMPLE_WIDTH-1:0] re,
                                       input logic [SAMPLE_WIDTH-1:0] im,
                                       input logic last);
        stim_step_t st;
        st.kind = STEP_ITEM;
        st.op   = OP_SAMPLE;
        // Slot and position are unused on a sample and carry noise.
        st.slot = SLOT_W'($urandom);
        st.ppos = PPOS_W'($urandom);
        st.re   = re;
        st.im   = im;
        st.last = last;
        st.reg_idx = REG_MODE;
        st.reg_val = '0;
        pending_steps.push_back(st);
        items_queued++;
    endfunction

    function automatic void add_cfg(input logic idx, input logic [CNT_W-1:0] val);
        stim_step_t st;
        st = '{kind: STEP_CFG, default: '0};
        st.reg_idx = idx;
        st.reg_val = val;
        pending_steps.push_back(st);
    endfunction

    function automatic void add_drain();
        stim_step_t st;
        st = '{kind: STEP_DRAIN, default: '0};
        pending_steps.push_back(st);
    endfunction

    // Loads slots 0..n-1, mostly with ascending positions close to the symbol start.
    function automatic void load_table(input int n);
        int  pos;
        bit  scattered;
        scattered = ($urandom_range(0, 5) == 0);
        pos = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            if (scattered)
                add_load(SLOT_W'(i), PPOS_W'($urandom_range(0, 1023)),
                         SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
            else
                add_load(SLOT_W'(i), PPOS_W'(pos),
                         SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
            pos += $urandom_range(0, 4);
        end
    endfunction

    function automatic void build_directed_part();
        // No pilots in use: samples pass one for one, extremes of the sample range.
        add_sample(16'h8000, 16'h7fff, 1'b0);
        add_sample(16'h7fff, 16'h8000, 1'b1);

        // Two pilots due at the symbol start, two left over for the trailing burst.
        add_load(4'd0, 10'd0, 16'h7fff, 16'h8000);
        add_load(4'd1, 10'd1, 16'h8000, 16'h7fff);
        add_load(4'd2, 10'd5, 16'h1234, 16'hedcb);
        add_load(4'd3, 10'd1023, 16'hffff, 16'h0000);
        add_cfg(REG_COUNT, 5'd4);
        add_sample(16'h0001, 16'hfffe, 1'b0);
        add_sample(16'h0000, 16'hffff, 1'b0);
        add_sample(16'h5555, 16'haaaa, 1'b1);

        // Removal drops positions 0, 1 and 5; the last sample sits on a pilot.
        // The sender also holds off mid symbol until every result is in.
        add_cfg(REG_MODE, CNT_W'(MODE_REMOVE));
        add_sample(16'h0101, 16'h0202, 1'b0);
        add_sample(16'h0303, 16'h0404, 1'b0);
        add_sample(16'h0505, 16'h0606, 1'b0);
        add_drain();
        add_sample(16'h0707, 16'h0808, 1'b0);
        add_sample(16'h0909, 16'h0a0a, 1'b0);
        add_sample(16'h0b0b, 16'h0c0c, 1'b1);

        // Table out of order: the second pilot has passed and only trails the symbol.
        add_load(4'd0, 10'd3, 16'h4000, 16'hc000);
        add_load(4'd1, 10'd1, 16'hc000, 16'h4000);
        add_cfg(REG_MODE, CNT_W'(MODE_INSERT));
        add_cfg(REG_COUNT, 5'd2);
        for (int i = 0; i < 4; i++)
            add_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), i == 3);
    endfunction

    function automatic void build_random_part();
        logic [CNT_W-1:0] cnt_val;
        int  n_sym;
        int  sym_len;
        bit  open_end;
        // Every slot holds a value before any count can reach it.
        load_table(MAX_PILOTS);
        while (items_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0)
                load_table($urandom_range(1, MAX_PILOTS));
            case ($urandom_range(0, 7))
                0:       cnt_val = '0;
                1, 2:    cnt_val = CNT_W'(MAX_PILOTS);
                3:       cnt_val = CNT_W'($urandom_range(MAX_PILOTS + 1, 31));
                default: cnt_val = CNT_W'($urandom_range(1, MAX_PILOTS - 1));
            endcase
            if ($urandom_range(0, 3) != 0)
                add_cfg(REG_MODE,
                        CNT_W'($urandom_range(0, 1) ? MODE_REMOVE : MODE_INSERT));
            add_cfg(REG_COUNT, cnt_val);
            // A phase may stop mid symbol so the next setting lands on a running symbol.
            open_end = ($urandom_range(0, 4) == 0);
            n_sym = $urandom_range(1, 3);
            for (int s = 0; s < n_sym; s++) begin
                sym_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
                for (int i = 0; i < sym_len; i++) begin
                    if (i == sym_len / 2 && $urandom_range(0, 3) == 0)
                        add_drain();
                    if ($urandom_range(0, 19) == 0)
                        add_load(SLOT_W'($urandom_range(0, MAX_PILOTS - 1)),
                                 PPOS_W'($urandom_range(0, 1023)),
                                 SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom));
                    add_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom),
                               (i == sym_len - 1) && !(open_end && s == n_sym - 1));
                end
            end
        end
    endfunction

    // ---------------------------------------------------------------- prediction

    function automatic void store_pilot(input stim_step_t st);
        tbl_pos[st.slot] = st.ppos;
        tbl_re[st.slot]  = st.re;
        tbl_im[st.slot]  = st.im;
    endfunction

    // Works out the carriers that one sample causes and queues them in order.
    function automatic void predict_carriers(input stim_step_t st);
        carrier_out_t run_buf [MAX_PILOTS + 1];
        carrier_out_t data_out;
        int           n;
        int unsigned  in_use;
        n = 0;
        in_use = (cfg_count > MAX_PILOTS) ? MAX_PILOTS : cfg_count;
        data_out = '{re: st.re, im: st.im, pilot: 1'b0, run_end: 1'b0, sym_end: 1'b0};
        if (cfg_mode == MODE_INSERT) begin
            // Pilots due at the current output position go out ahead of the sample.
            while (tbl_ptr < in_use && tbl_pos[tbl_ptr] == out_pos) begin
                run_buf[n] = '{re: tbl_re[tbl_ptr], im: tbl_im[tbl_ptr], pilot: 1'b1,
                               run_end: 1'b0, sym_end: 1'b0};
                n++;
                tbl_ptr++;
                out_pos++;
            end
            run_buf[n] = data_out;
            n++;
            out_pos++;
            // At the symbol end every pilot not yet sent follows the sample.
            if (st.last) begin
                while (tbl_ptr < in_use) begin
                    run_buf[n] = '{re: tbl_re[tbl_ptr], im: tbl_im[tbl_ptr], pilot: 1'b1,
                                   run_end: 1'b0, sym_end: 1'b0};
                    n++;
                    tbl_ptr++;
                end
            end
        end else begin
            if (tbl_ptr < in_use && tbl_pos[tbl_ptr] == out_pos)
                tbl_ptr++;
            else begin
                run_buf[n] = data_out;
                n++;
            end
            out_pos++;
        end
        if (n > 0) begin
            run_buf[n-1].run_end = 1'b1;
            run_buf[n-1].sym_end = st.last;
        end
        if (st.last) begin
            out_pos = '0;
            tbl_ptr = 0;
        end
        for (int i = 0; i < n; i++)
            expected_carriers.push_back(run_buf[i]);
    endfunction

    // ---------------------------------------------------------------- driver

    // Input transfers, register writes and pauses, taken in plan order.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
            tx_busy = 0;
            tx_gap  = 0;
        end else begin
            cfg_en_nxt = 1'b0;
            if (s_tvalid && s_tready) begin
                if (tx_cur.op == OP_LOAD)
                    store_pilot(tx_cur);
                else
                    predict_carriers(tx_cur);
                tx_busy = 0;
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (!tx_busy) begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_steps.size() > 0) begin
                    head = pending_steps[0];
                    case (head.kind)
                        STEP_ITEM: begin
                            tx_cur = pending_steps.pop_front();
                            tx_busy = 1;
                            tx_word = '0;
                            tx_word[S_SLOT_LO +: SLOT_W]       = head.slot;
                            tx_word[S_PPOS_LO +: PPOS_W]       = head.ppos;
                            tx_word[S_RE_LO   +: SAMPLE_WIDTH] = head.re;
                            tx_word[S_IM_LO   +: SAMPLE_WIDTH] = head.im;
                            s_tdata <= tx_word;
                            s_tuser <= head.op;
                            s_tlast <= head.last;
                        end
                        STEP_CFG: begin
                            // Registers change only once the block has gone quiet.
                            if (settle_cycles >= SETTLE_CYCLES) begin
                                void'(pending_steps.pop_front());
                                cfg_en_nxt = 1'b1;
                                cfg_index   <= head.reg_idx;
                                cfg_wr_data <= head.reg_val;
                                if (head.reg_idx == REG_MODE)
                                    cfg_mode = head.reg_val[0];
                                else
                                    cfg_count = head.reg_val;
                            end
                        end
                        default: begin
                            if (settle_cycles >= SETTLE_CYCLES)
                                void'(pending_steps.pop_front());
                        end
                    endcase
                end
            end
            s_tvalid  <= tx_busy;
            cfg_wr_en <= cfg_en_nxt;
        end
    end

    // Counts cycles with nothing in flight; sampled away from the active edge.
    always @(negedge aclk) begin
        if (!aresetn || expected_carriers.size() != 0 || s_tvalid || m_tvalid)
            settle_cycles <= 0;
        else if (settle_cycles < SETTLE_CYCLES)
            settle_cycles <= settle_cycles + 1;
    end

    // ---------------------------------------------------------------- receiver

    // Result-side backpressure: a random stall before each transfer, sometimes none.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 39) == 0)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else
                m_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string label,
                                        input logic [SAMPLE_WIDTH-1:0] exp_val,
                                        input logic [SAMPLE_WIDTH-1:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h",
                     $realtime, label, exp_val, act_val);
            error_count++;
        end
    endfunction

    // Each result transfer is checked against the oldest expected carrier.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = '{re: m_tdata[SAMPLE_WIDTH-1:0],
                     im: m_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH],
                     pilot: m_tuser[0], run_end: m_tuser[1], sym_end: m_tlast};
            if (expected_carriers.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $realtime, seen);
                error_count++;
            end else begin
                want = expected_carriers.pop_front();
                check_field("out_real", want.re, seen.re);
                check_field("out_imag", want.im, seen.im);
                check_field("is_pilot", SAMPLE_WIDTH'(want.pilot),
                            SAMPLE_WIDTH'(seen.pilot));
                check_field("run_end", SAMPLE_WIDTH'(want.run_end),
                            SAMPLE_WIDTH'(seen.run_end));
                check_field("symbol_end", SAMPLE_WIDTH'(want.sym_end),
                            SAMPLE_WIDTH'(seen.sym_end));
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles", $realtime, idle_cycles);
                $display("ofdm_pilot_insert_remove_core regression: fail");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        build_directed_part();
        build_random_part();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // Wait for the plan to run out and every expected carrier to arrive.
        do
            @(negedge aclk);
        while (pending_steps.size() != 0 || s_tvalid || expected_carriers.size() != 0);
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_carriers.size() == 0)
            $display("ofdm_pilot_insert_remove_core regression: pass");
        else
            $display("ofdm_pilot_insert_remove_core regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/ofdm_pir_pkg.sv
design/ofdm_pir_ram.sv
design/ofdm_pilot_insert_remove_core.sv
verif/ofdm_pilot_insert_remove_core_test.sv
